>>> rtl/core/bfh_pkg.sv
package bfh_pkg;

    localparam int FILTER_BITS = 65536;
    localparam int NUM_FILTERS = 3;
    localparam int POS_W       = $clog2(FILTER_BITS);
    localparam int FSEL_W      = 2;
    localparam int ROW_W       = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
    localparam int ADDR_W      = ROW_W + POS_W;
    localparam int DEPTH       = NUM_FILTERS * FILTER_BITS;
    localparam int NUM_HASH    = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] BKDR_SEED = 32'd131;
    localparam logic [31:0] DJB_START = 32'd5381;
    localparam logic [31:0] JS_START  = 32'd1315423911;
    localparam logic [31:0] RS_MULT   = 32'd378551;
    localparam logic [31:0] RS_START  = 32'd63689;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    // One finished key as handed from the hash front to the filter back
    typedef struct packed {
        op_t                                  op;
        logic                                 in_range;
        logic [ROW_W-1:0]                     row;
        logic [NUM_HASH-1:0][POS_W-1:0]       pos;
    } key_req_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_FINISH
    } back_state_t;

    // Bit position: hash masked to 31 bits, modulo a power-of-two size
    function automatic logic [POS_W-1:0] hash_pos(input logic [31:0] h);
        logic [30:0] m;
        begin
            m = h[30:0];
            hash_pos = POS_W'(m % FILTER_BITS);
        end
    endfunction

endpackage

>>> rtl/core/bloom_filter_five_string_hashes.sv
// Channel | Handshake            | Fields
// input   | push / full          | op, filter_select, key_byte, last
// result  | empty / pop          | present
//
// One key byte is taken a cycle while full is low; hashes update in that cycle.
// A finished key waits in a four-entry request queue; for an in-range key the back
// passes an idle state, five memory accesses (one per cycle) and a finish state,
// and it takes no new key before it is through with the last one.
// After reset the back clears all NUM_FILTERS*FILTER_BITS filter bits (196608)
// before serving keys; up to four keys queue up meanwhile.
// full rises when the queue fills; a held result stalls only queries.
module bloom_filter_five_string_hashes (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       op,
    input  logic [1:0] filter_select,
    input  logic [7:0] key_byte,
    input  logic       last,
    output logic       empty,
    input  logic       pop,
    output logic       present
);
    import bfh_pkg::*;

    key_req_t f_data, b_data;
    logic     f_push, q_full, q_empty, b_pop;

    bfh_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .op(op),
        .filter_select(filter_select), .key_byte(key_byte), .last(last),
        .q_full(q_full), .q_push(f_push), .q_data(f_data), .full(full)
    );

    bfh_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(f_push), .wr_data(f_data),
        .q_full(q_full), .rd_en(b_pop), .rd_data(b_data), .q_empty(q_empty)
    );

    bfh_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(b_data),
        .q_pop(b_pop), .empty(empty), .pop(pop), .present(present)
    );

endmodule

>>> rtl/core/bfh_front.sv
module bfh_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              op,
    input  logic [1:0]        filter_select,
    input  logic [7:0]        key_byte,
    input  logic              last,
    input  logic              q_full,
    output logic              q_push,
    output bfh_pkg::key_req_t q_data,
    output logic              full
);
    import bfh_pkg::*;

    logic [31:0] bkdr_reg, ap_reg, djb_reg, js_reg, rs_reg, rsf_reg;
    logic [31:0] bkdr_next, ap_next, djb_next, js_next, rs_next, rsf_next;
    logic        par_reg, par_next;
    logic [31:0] c;
    logic        take;

    assign full = q_full;
    assign take = push && !q_full;
    assign c    = {{24{key_byte[7]}}, key_byte};

    // Advance the five hashes by one byte
    always_comb
    begin
        bkdr_next = bkdr_reg * BKDR_SEED + c;
        if (!par_reg)
            ap_next = ap_reg ^ ((ap_reg << 7) ^ c ^ (ap_reg >> 3));
        else
            ap_next = ap_reg ^ ~((ap_reg << 11) ^ c ^ (ap_reg >> 5));
        par_next = ~par_reg;
        djb_next = djb_reg + (djb_reg << 5) + c;
        js_next  = js_reg ^ ((js_reg << 5) + c + (js_reg >> 2));
        rs_next  = rs_reg * rsf_reg + c;
        rsf_next = rsf_reg * RS_MULT;
    end

    // Hold hashes between bytes; restart them after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bkdr_reg <= '0;
            ap_reg   <= '0;
            djb_reg  <= DJB_START;
            js_reg   <= JS_START;
            rs_reg   <= '0;
            rsf_reg  <= RS_START;
            par_reg  <= 1'b0;
        end
        else if (take)
        begin
            if (last)
            begin
                bkdr_reg <= '0;
                ap_reg   <= '0;
                djb_reg  <= DJB_START;
                js_reg   <= JS_START;
                rs_reg   <= '0;
                rsf_reg  <= RS_START;
                par_reg  <= 1'b0;
            end
            else
            begin
                bkdr_reg <= bkdr_next;
                ap_reg   <= ap_next;
                djb_reg  <= djb_next;
                js_reg   <= js_next;
                rs_reg   <= rs_next;
                rsf_reg  <= rsf_next;
                par_reg  <= par_next;
            end
        end
    end

    // Classify the finished key into a request for the back
    always_comb
    begin
        q_push           = take && last;
        q_data.op        = op_t'(op);
        q_data.in_range  = ({30'd0, filter_select} < 32'(NUM_FILTERS));
        q_data.row       = ROW_W'(filter_select);
        q_data.pos[0]    = hash_pos(bkdr_next);
        q_data.pos[1]    = hash_pos(ap_next);
        q_data.pos[2]    = hash_pos(djb_next);
        q_data.pos[3]    = hash_pos(js_next);
        q_data.pos[4]    = hash_pos(rs_next);
    end

endmodule

>>> rtl/core/bfh_queue.sv
module bfh_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  bfh_pkg::key_req_t wr_data,
    output logic              q_full,
    input  logic              rd_en,
    output bfh_pkg::key_req_t rd_data,
    output logic              q_empty
);
    import bfh_pkg::*;

    key_req_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign q_full  = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_data = mem_reg[rp_reg];

    // Store requests
    always_ff @(posedge clk)
    begin
        if (wr_en && !q_full)
            mem_reg[wp_reg] <= wr_data;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en && !q_full)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en && !q_empty)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_W+1)'(wr_en && !q_full)
                               - (QPTR_W+1)'(rd_en && !q_empty);
        end
    end

endmodule

>>> rtl/core/bfh_back.sv
module bfh_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  bfh_pkg::key_req_t q_data,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output logic              present
);
    import bfh_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int K_W   = $clog2(NUM_HASH + 1);

    logic                     mem [DEPTH];
    back_state_t              st_reg, st_next;
    logic [CNT_W-1:0]         clr_reg;
    logic [K_W-1:0]           k_reg;
    logic                     rd_reg;
    logic                     rdv_reg;
    logic                     all_reg;
    logic                     ovalid_reg;
    logic                     oval_reg;
    logic                     we;
    logic                     wdat;
    logic [ADDR_W-1:0]        waddr;
    logic [ADDR_W-1:0]        raddr;
    logic                     last_k;

    assign last_k  = (k_reg == K_W'(NUM_HASH - 1));
    assign raddr   = ADDR_W'(q_data.row) * ADDR_W'(FILTER_BITS)
                   + ADDR_W'(q_data.pos[k_reg[2:0]]);
    assign empty   = !ovalid_reg;
    assign present = oval_reg;

    // Next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_CLEAR:  if (clr_reg == CNT_W'(DEPTH - 1)) st_next = ST_IDLE;
            ST_IDLE:   if (!q_empty)
                       begin
                           if (q_data.in_range) st_next = ST_ACCESS;
                           else                 st_next = ST_FINISH;
                       end
            ST_ACCESS: if (last_k) st_next = ST_FINISH;
            ST_FINISH: if (q_data.op == OP_INSERT || !ovalid_reg || pop)
                           st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        we    = 1'b0;
        wdat  = 1'b0;
        waddr = raddr;
        q_pop = 1'b0;
        unique case (st_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = ADDR_W'(clr_reg);
            end
            ST_ACCESS:
            begin
                we   = (q_data.op == OP_INSERT);
                wdat = 1'b1;
            end
            ST_FINISH:
                q_pop = (q_data.op == OP_INSERT || !ovalid_reg || pop);
            default: ;
        endcase
    end

    // Filter memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdat;
        rd_reg <= mem[raddr];
    end

    // Sequencer registers, AND of read bits, result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_CLEAR;
            clr_reg    <= '0;
            k_reg      <= '0;
            rdv_reg    <= 1'b0;
            all_reg    <= 1'b1;
            ovalid_reg <= 1'b0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            rdv_reg <= (st_reg == ST_ACCESS);
            if (st_reg == ST_IDLE)
            begin
                k_reg   <= '0;
                all_reg <= q_data.in_range;
            end
            else
            begin
                if (st_reg == ST_ACCESS)
                    k_reg <= k_reg + 1'b1;
                if (rdv_reg && !rd_reg)
                    all_reg <= 1'b0;
            end
            if (pop && ovalid_reg)
                ovalid_reg <= 1'b0;
            if (st_reg == ST_FINISH && q_pop && q_data.op == OP_QUERY)
            begin
                ovalid_reg <= 1'b1;
                oval_reg   <= all_reg && !(rdv_reg && !rd_reg);
            end
        end
    end

endmodule

>>> rtl/core/bfh_checker.sv
module bfh_sva (
    input logic       clk,
    input logic       rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       present
);
    // A waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(present)))
        else $error("result changed while waiting");

    // Handshake outputs are always known
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({full, empty}))
        else $error("unknown handshake output");

    // A waiting result carries a known value
    a_present_known: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !$isunknown(present))
        else $error("unknown result value");

    // Nothing is shown right after reset release
    a_rst: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result after reset");
endmodule

bind bloom_filter_five_string_hashes bfh_sva u_bfh_sva (
    .clk(clk), .rst_n(rst_n), .full(full),
    .empty(empty), .pop(pop), .present(present)
);
